// File: sv/plob_pkg.sv
// Shared types, constants and search functions for the price level book.
// No dependencies; every other file of the block but plob_ram imports it.
package plob_pkg;

    localparam int PRICE_W    = 10;
    localparam int AMT_W      = 32;
    localparam int SPREAD_W   = 11;
    localparam int ROW_BITS   = 32;
    localparam int BIT_W      = 5;
    localparam int MAX_LEVELS = 1 << PRICE_W;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;
    localparam logic SIDE_ASK   = 1'b0;
    localparam logic SIDE_BID   = 1'b1;

    typedef logic [PRICE_W-1:0]         price_t;
    typedef logic signed [AMT_W-1:0]    amount_t;
    typedef logic signed [SPREAD_W-1:0] spread_t;
    typedef logic [ROW_BITS-1:0]        row_t;
    typedef logic [BIT_W-1:0]           bit_idx_t;

    // controller to datapath
    typedef struct packed {
        logic accept;    // take request, launch level reads
        logic update;    // read-modify-write of the level
        logic row_rd;    // pick best rows, read their present words
        logic bit_rd;    // pick best bits, read best amounts
        logic load_out;  // load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } stat_t;

    // index of highest set bit, 0 when none
    function automatic bit_idx_t hi_index(row_t v);
        bit_idx_t idx;
        idx = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (v[i])
            begin
                idx = bit_idx_t'(i);
            end
        end
        return idx;
    endfunction

    // index of lowest set bit, 0 when none
    function automatic bit_idx_t lo_index(row_t v);
        bit_idx_t idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = bit_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: sv/plob_req_if.sv
// Request channel: valid/ready handshake with the request fields.
// Depends on plob_pkg.
interface plob_req_if;
    import plob_pkg::*;

    logic    valid;
    logic    ready;
    logic    req_type;
    logic    side;
    price_t  price;
    amount_t amount;

    modport source (output valid, output req_type, output side, output price,
                    output amount, input ready);
    modport sink   (input valid, input req_type, input side, input price,
                    input amount, output ready);
endinterface

// File: sv/plob_rsp_if.sv
// Result channel: valid/ready handshake with best bid, best ask and spread.
// Depends on plob_pkg.
interface plob_rsp_if;
    import plob_pkg::*;

    logic    valid;
    logic    ready;
    logic    best_bid_valid;
    price_t  best_bid_price;
    amount_t best_bid_amount;
    logic    best_ask_valid;
    price_t  best_ask_price;
    amount_t best_ask_amount;
    logic    spread_valid;
    spread_t spread_ticks;
    logic    book_empty;

    modport source (output valid, output best_bid_valid, output best_bid_price,
                    output best_bid_amount, output best_ask_valid,
                    output best_ask_price, output best_ask_amount,
                    output spread_valid, output spread_ticks, output book_empty,
                    input ready);
    modport sink   (input valid, input best_bid_valid, input best_bid_price,
                    input best_bid_amount, input best_ask_valid,
                    input best_ask_price, input best_ask_amount,
                    input spread_valid, input spread_ticks, input book_empty,
                    output ready);
endinterface

// File: sv/plob_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module plob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/plob_ctrl.sv
// Sequencer for the price level book: one request at a time through
// level update, row search, bit search and result load. Depends on plob_pkg.
module plob_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            ready,
    output plob_pkg::cmd_t  cmd,
    input  plob_pkg::stat_t stat
);
    import plob_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_FIND_ROW,
        S_FIND_BIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FIND_ROW;
            end
            S_FIND_ROW:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_FIND_BIT;
            end
            S_FIND_BIT:
            begin
                cmd.bit_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (!stat.out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ready = (state_reg == S_IDLE);
endmodule

// File: sv/plob_dp.sv
// Datapath of the price level book: present words and level amounts in RAM,
// row summary flags, best level search and the result register.
// Depends on plob_pkg, plob_ram and plob_rsp_if.
module plob_dp #(
    parameter int PRICE_LEVELS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  plob_pkg::cmd_t    cmd,
    output plob_pkg::stat_t   stat,
    input  logic              req_type,
    input  logic              side,
    input  plob_pkg::price_t  price,
    input  plob_pkg::amount_t amount,
    plob_rsp_if.source        rsp
);
    import plob_pkg::*;

    // prices are 10 bits, so levels past the field range are never touched
    localparam int LEVELS = (PRICE_LEVELS < MAX_LEVELS) ? PRICE_LEVELS : MAX_LEVELS;
    localparam int ROWS   = (LEVELS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW     = $clog2(LEVELS);

    // request registers
    logic    req_type_reg;
    logic    side_reg;
    price_t  price_reg;
    amount_t amount_reg;
    logic    win_reg;

    // one flag per present word row: row holds at least one level
    logic [ROWS-1:0] bid_rows_reg;
    logic [ROWS-1:0] ask_rows_reg;

    // search registers
    logic [ROW_AW-1:0] bid_row_reg;
    logic [ROW_AW-1:0] ask_row_reg;
    logic              bid_any_reg;
    logic              ask_any_reg;
    price_t            bid_price_reg;
    price_t            ask_price_reg;

    // result registers
    logic    out_valid_reg;
    logic    best_bid_valid_reg;
    price_t  best_bid_price_reg;
    amount_t best_bid_amount_reg;
    logic    best_ask_valid_reg;
    price_t  best_ask_price_reg;
    amount_t best_ask_amount_reg;
    logic    spread_valid_reg;
    spread_t spread_ticks_reg;
    logic    book_empty_reg;

    // RAM ports
    logic [ROW_AW-1:0] bid_pres_raddr;
    logic [ROW_AW-1:0] ask_pres_raddr;
    row_t              bid_pres_rdata;
    row_t              ask_pres_rdata;
    logic [AW-1:0]     bid_amt_raddr;
    logic [AW-1:0]     ask_amt_raddr;
    logic [AMT_W-1:0]  bid_amt_rdata;
    logic [AMT_W-1:0]  ask_amt_rdata;
    logic              bid_we;
    logic              ask_we;
    logic              pres_re;
    logic              amt_re;

    // update path
    logic [ROW_AW-1:0] upd_row;
    bit_idx_t          upd_bit;
    logic              upd_flag;
    row_t              cur_row;
    row_t              new_row;
    logic              cur_present;
    amount_t           old_amt;
    amount_t           new_amt;
    logic              new_present;
    logic              do_write;

    // search path
    bit_idx_t bid_row_idx;
    bit_idx_t ask_row_idx;
    bit_idx_t bid_bit;
    bit_idx_t ask_bit;
    price_t   bid_price_next;
    price_t   ask_price_next;
    logic     win_next;

    assign win_next = (32'(price) < 32'(PRICE_LEVELS));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg <= req_type;
            side_reg     <= side;
            price_reg    <= price;
            amount_reg   <= amount;
            win_reg      <= win_next;
        end
    end

    // ---------------- level read-modify-write ----------------
    assign upd_row = price_reg[BIT_W +: ROW_AW];
    assign upd_bit = price_reg[BIT_W-1:0];

    always_comb
    begin
        if (side_reg == SIDE_BID)
        begin
            upd_flag = bid_rows_reg[upd_row];
            cur_row  = upd_flag ? bid_pres_rdata : '0;
            old_amt  = amount_t'(bid_amt_rdata);
        end
        else
        begin
            upd_flag = ask_rows_reg[upd_row];
            cur_row  = upd_flag ? ask_pres_rdata : '0;
            old_amt  = amount_t'(ask_amt_rdata);
        end
        cur_present = cur_row[upd_bit];
        if (!cur_present)
        begin
            old_amt = '0;
        end
        if (req_type_reg == REQ_ADD)
        begin
            new_amt     = old_amt + amount_reg;
            new_present = 1'b1;
            do_write    = win_reg;
        end
        else
        begin
            new_amt     = old_amt - amount_reg;
            new_present = (new_amt != '0);
            do_write    = win_reg && cur_present;
        end
        new_row          = cur_row;
        new_row[upd_bit] = new_present;
    end

    assign bid_we = cmd.update && do_write && (side_reg == SIDE_BID);
    assign ask_we = cmd.update && do_write && (side_reg == SIDE_ASK);

    // ---------------- best level search ----------------
    assign bid_row_idx = hi_index(row_t'(bid_rows_reg));
    assign ask_row_idx = lo_index(row_t'(ask_rows_reg));
    assign bid_bit     = hi_index(bid_pres_rdata);
    assign ask_bit     = lo_index(ask_pres_rdata);

    assign bid_price_next = bid_any_reg ? price_t'({bid_row_reg, bid_bit}) : '0;
    assign ask_price_next = ask_any_reg ? price_t'({ask_row_reg, ask_bit}) : '0;

    assign pres_re        = cmd.accept || cmd.row_rd;
    assign amt_re         = cmd.accept || cmd.bit_rd;
    assign bid_pres_raddr = cmd.accept ? price[BIT_W +: ROW_AW] : bid_row_idx[ROW_AW-1:0];
    assign ask_pres_raddr = cmd.accept ? price[BIT_W +: ROW_AW] : ask_row_idx[ROW_AW-1:0];
    assign bid_amt_raddr  = cmd.accept ? price[AW-1:0] : bid_price_next[AW-1:0];
    assign ask_amt_raddr  = cmd.accept ? price[AW-1:0] : ask_price_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.row_rd)
        begin
            bid_row_reg <= bid_row_idx[ROW_AW-1:0];
            ask_row_reg <= ask_row_idx[ROW_AW-1:0];
            bid_any_reg <= |bid_rows_reg;
            ask_any_reg <= |ask_rows_reg;
        end
        if (cmd.bit_rd)
        begin
            bid_price_reg <= bid_price_next;
            ask_price_reg <= ask_price_next;
        end
    end

    // ---------------- memories ----------------
    plob_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_bid_pres (
        .clk   (clk),
        .we    (bid_we),
        .waddr (upd_row),
        .wdata (new_row),
        .re    (pres_re),
        .raddr (bid_pres_raddr),
        .rdata (bid_pres_rdata)
    );

    plob_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_ask_pres (
        .clk   (clk),
        .we    (ask_we),
        .waddr (upd_row),
        .wdata (new_row),
        .re    (pres_re),
        .raddr (ask_pres_raddr),
        .rdata (ask_pres_rdata)
    );

    plob_ram #(.WIDTH(AMT_W), .DEPTH(LEVELS)) u_bid_amt (
        .clk   (clk),
        .we    (bid_we),
        .waddr (price_reg[AW-1:0]),
        .wdata (new_amt),
        .re    (amt_re),
        .raddr (bid_amt_raddr),
        .rdata (bid_amt_rdata)
    );

    plob_ram #(.WIDTH(AMT_W), .DEPTH(LEVELS)) u_ask_amt (
        .clk   (clk),
        .we    (ask_we),
        .waddr (price_reg[AW-1:0]),
        .wdata (new_amt),
        .re    (amt_re),
        .raddr (ask_amt_raddr),
        .rdata (ask_amt_rdata)
    );

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_rows_reg  <= '0;
            ask_rows_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (bid_we)
            begin
                bid_rows_reg[upd_row] <= |new_row;
            end
            if (ask_we)
            begin
                ask_rows_reg[upd_row] <= |new_row;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            best_bid_valid_reg  <= bid_any_reg;
            best_bid_price_reg  <= bid_price_reg;
            best_bid_amount_reg <= bid_any_reg ? amount_t'(bid_amt_rdata) : '0;
            best_ask_valid_reg  <= ask_any_reg;
            best_ask_price_reg  <= ask_price_reg;
            best_ask_amount_reg <= ask_any_reg ? amount_t'(ask_amt_rdata) : '0;
            spread_valid_reg    <= bid_any_reg && ask_any_reg;
            spread_ticks_reg    <= (bid_any_reg && ask_any_reg)
                                 ? spread_t'({1'b0, ask_price_reg})
                                   - spread_t'({1'b0, bid_price_reg})
                                 : '0;
            book_empty_reg      <= !bid_any_reg && !ask_any_reg;
        end
    end

    assign stat.out_stall = out_valid_reg && !rsp.ready;

    assign rsp.valid           = out_valid_reg;
    assign rsp.best_bid_valid  = best_bid_valid_reg;
    assign rsp.best_bid_price  = best_bid_price_reg;
    assign rsp.best_bid_amount = best_bid_amount_reg;
    assign rsp.best_ask_valid  = best_ask_valid_reg;
    assign rsp.best_ask_price  = best_ask_price_reg;
    assign rsp.best_ask_amount = best_ask_amount_reg;
    assign rsp.spread_valid    = spread_valid_reg;
    assign rsp.spread_ticks    = spread_ticks_reg;
    assign rsp.book_empty      = book_empty_reg;
endmodule

// File: sv/price_level_order_book.sv
// Price level order book: aggregated quantity per price level, bid and ask.
// A request runs through the update, row search, bit search and finish states
// (level read, level write, row search, bit search, amount read); a new request is
// taken only once the result is loaded, later while the result register is not taken.
// Reset: asynchronous; row present flags clear at once, no clearing pass.
// Depends on plob_pkg, plob_req_if, plob_rsp_if, plob_ctrl, plob_dp.
module price_level_order_book #(
    parameter int PRICE_LEVELS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    plob_req_if.sink   req,
    plob_rsp_if.source rsp
);
    import plob_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  ready;

    plob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .ready     (ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    plob_dp #(.PRICE_LEVELS(PRICE_LEVELS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_type (req.req_type),
        .side     (req.side),
        .price    (req.price),
        .amount   (req.amount),
        .rsp      (rsp)
    );

    assign req.ready = ready;
endmodule
